// ===== hdl/hvn_pkg.sv =====
// Shared constants, types and helpers for the heightmap vertex normal block.
package hvn_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COORD_W  = 6;
  localparam int DIM_W    = 7;
  localparam int HGT_W    = 8;
  localparam int SUM_W    = 11;
  localparam int MAG_W    = 10;
  localparam int SQ_W     = 20;
  localparam int LEN_W    = 22;
  localparam int Q_W      = 16;
  localparam int ACC_W    = 56;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DIVISOR     = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } root_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(2)) r = DIM_W'(2);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== hdl/hvn_store.sv =====
// Height sample memory with one write port and one registered read port.
module hvn_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [hvn_pkg::ADDR_W-1:0] waddr,
  input  logic [hvn_pkg::HGT_W-1:0]  wdata,
  input  logic [hvn_pkg::ADDR_W-1:0] raddr,
  output logic [hvn_pkg::HGT_W-1:0]  rdata
);

  logic [hvn_pkg::HGT_W-1:0] mem [0:hvn_pkg::DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/hvn_root.sv =====
// Bit-serial unit: largest q with q*q*len2 <= tgt_sq<<30, one bit per cycle.
module hvn_root (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hvn_pkg::SQ_W-1:0]  tgt_sq,
  input  logic [hvn_pkg::LEN_W-1:0] len2,
  output hvn_pkg::root_stat_t       stat
);

  logic                       busy;
  logic [3:0]                 k;
  logic [hvn_pkg::ACC_W-1:0]  p;
  logic [hvn_pkg::ACC_W-1:0]  ql;
  logic [hvn_pkg::Q_W-1:0]    q;
  logic                       done;
  logic [hvn_pkg::ACC_W-1:0]  tgt;
  logic [hvn_pkg::ACC_W-1:0]  cand;
  logic [4:0]                 sh_ql;
  logic                       fits;

  assign tgt   = hvn_pkg::ACC_W'(tgt_sq) << 30;
  assign sh_ql = {1'b0, k} + 5'd1;
  assign cand  = p + (ql << sh_ql) + (hvn_pkg::ACC_W'(len2) << {k, 1'b0});
  assign fits  = cand <= tgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k  <= 4'd15;
      p  <= '0;
      ql <= '0;
      q  <= '0;
    end else if (busy) begin
      k <= k - 4'd1;
      if (fits) begin
        p  <= cand;
        ql <= ql + (hvn_pkg::ACC_W'(len2) << k);
        q  <= q | (hvn_pkg::Q_W'(1) << k);
      end
    end
  end

  assign stat.done = done;
  assign stat.q    = q;

endmodule

// ===== hdl/heightmap_vertex_normals.sv =====
// Top level: configuration, query sequencer and result register.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   op, col, row, height
//   out      output     out_valid/out_stall normal_x, normal_y, normal_z, bad_coord
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A write is accepted and then performed in the decode state. A query is accepted and
// decoded; out of the grid it goes straight to output, else it makes 9 reads on the
// single registered read port, then sums, squares and makes 3 passes through the
// bit-serial root unit. Every result waits in the output state until it is taken.
// Reset is synchronous; the height memory is not cleared.
// in_stall stays high from acceptance until the write is done or the result is taken.
module heightmap_vertex_normals (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [5:0]  col,
  input  logic [5:0]  row,
  input  logic [7:0]  height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] normal_x,
  output logic [14:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic        bad_coord,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_GO   = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic [7:0] height_divisor;

  logic       op_q;
  logic [5:0] col_q;
  logic [5:0] row_q;
  logic [7:0] height_q;
  logic [6:0] wc;
  logic [6:0] hc;
  logic [7:0] dc;
  logic       in_grid;

  logic [3:0] cnt;
  logic [1:0] comp;
  logic [7:0] nb [0:8];

  logic signed [10:0] sx;
  logic signed [10:0] sz;
  logic [9:0]         sy;
  logic signed [10:0] sx_c;
  logic signed [10:0] sz_c;
  logic [9:0]         sy_c;

  logic [19:0] sqv [0:2];
  logic [19:0] prod;
  logic [21:0] len2;
  logic [9:0]  mag;

  logic                      we;
  logic [hvn_pkg::ADDR_W-1:0] waddr;
  logic [hvn_pkg::ADDR_W-1:0] raddr;
  logic [7:0]                 rdata;
  logic [12:0]                wprod;
  logic [1:0]                 dx;
  logic [1:0]                 dy;
  logic [6:0]                 rr;
  logic [6:0]                 cc;
  logic [13:0]                rprod;

  logic                 root_start;
  hvn_pkg::root_stat_t  root_stat;
  logic                 comp_neg;
  logic [15:0]          res;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_OUT;
  assign in_grid   = ({1'b0, col_q} < wc) && ({1'b0, row_q} < hc);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= 7'd64;
      grid_height    <= 7'd64;
      height_divisor <= 8'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hvn_pkg::REG_GRID_WIDTH:  grid_width     <= cfg_data[6:0];
        hvn_pkg::REG_GRID_HEIGHT: grid_height    <= cfg_data[6:0];
        hvn_pkg::REG_DIVISOR:     height_divisor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wprod = row_q * wc;
  assign waddr = hvn_pkg::ADDR_W'(wprod + 13'(col_q));
  assign we    = state == S_EXEC && op_q == hvn_pkg::OP_WRITE && in_grid;

  always_comb begin
    unique case (cnt)
      4'd0: begin dx = 2'd0; dy = 2'd0; end
      4'd1: begin dx = 2'd1; dy = 2'd0; end
      4'd2: begin dx = 2'd2; dy = 2'd0; end
      4'd3: begin dx = 2'd0; dy = 2'd1; end
      4'd4: begin dx = 2'd1; dy = 2'd1; end
      4'd5: begin dx = 2'd2; dy = 2'd1; end
      4'd6: begin dx = 2'd0; dy = 2'd2; end
      4'd7: begin dx = 2'd1; dy = 2'd2; end
      4'd8: begin dx = 2'd2; dy = 2'd2; end
      default: begin dx = 2'd0; dy = 2'd0; end
    endcase
  end

  assign rr    = {1'b0, row_q} + 7'(dy) - 7'd1;
  assign cc    = {1'b0, col_q} + 7'(dx) - 7'd1;
  assign rprod = rr * wc;
  assign raddr = hvn_pkg::ADDR_W'(rprod + 14'(cc));

  hvn_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (height_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    logic       okx;
    logic       oky;
    logic [3:0] b;
    sx_c = '0;
    sz_c = '0;
    sy_c = '0;
    for (int k = 0; k < 4; k++) begin
      okx = (k % 2 == 1) ? ({1'b0, col_q} + 7'd1 < wc) : (col_q != 6'd0);
      oky = (k / 2 == 1) ? ({1'b0, row_q} + 7'd1 < hc) : (row_q != 6'd0);
      b   = 4'((k / 2) * 3 + (k % 2));
      if (okx && oky) begin
        sx_c = sx_c + 11'(nb[b]) - 11'(nb[b + 4'd1]);
        sz_c = sz_c + 11'(nb[b]) - 11'(nb[b + 4'd3]);
        sy_c = sy_c + 10'(dc);
      end
    end
  end

  always_comb begin
    unique case (cnt[1:0])
      2'd0: mag = sx[10] ? 10'(-sx) : sx[9:0];
      2'd1: mag = sy;
      2'd2: mag = sz[10] ? 10'(-sz) : sz[9:0];
      default: mag = '0;
    endcase
  end

  assign root_start = state == S_GO;

  hvn_root u_root (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .tgt_sq (sqv[comp]),
    .len2   (len2),
    .stat   (root_stat)
  );

  always_comb begin
    unique case (comp)
      2'd0: comp_neg = sx[10];
      2'd2: comp_neg = sz[10];
      default: comp_neg = 1'b0;
    endcase
    if (comp_neg) res = 16'(-root_stat.q);
    else if (root_stat.q > 16'd32767) res = 16'd32767;
    else res = root_stat.q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (op_q == hvn_pkg::OP_WRITE) state_next = S_IDLE;
        else if (!in_grid) state_next = S_OUT;
        else state_next = S_READ;
      end
      S_READ: if (cnt == 4'd9) state_next = S_SUM;
      S_SUM:  state_next = S_SQ;
      S_SQ:   if (cnt == 4'd3) state_next = S_GO;
      S_GO:   state_next = S_WAIT;
      S_WAIT: if (root_stat.done) state_next = (comp == 2'd2) ? S_OUT : S_GO;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q     <= op;
          col_q    <= col;
          row_q    <= row;
          height_q <= height;
          wc       <= hvn_pkg::clamp_dim(grid_width, 7'(hvn_pkg::MAX_COLS));
          hc       <= hvn_pkg::clamp_dim(grid_height, 7'(hvn_pkg::MAX_ROWS));
          dc       <= (height_divisor == 8'd0) ? 8'd1 : height_divisor;
        end
      end
      S_EXEC: begin
        cnt       <= '0;
        comp      <= '0;
        len2      <= '0;
        bad_coord <= !in_grid;
        normal_x  <= '0;
        normal_y  <= '0;
        normal_z  <= '0;
      end
      S_READ: begin
        if (cnt != 4'd0) nb[cnt - 4'd1] <= rdata;
        cnt <= cnt + 4'd1;
      end
      S_SUM: begin
        sx  <= sx_c;
        sy  <= sy_c;
        sz  <= sz_c;
        cnt <= '0;
      end
      S_SQ: begin
        prod <= mag * mag;
        if (cnt != 4'd0) begin
          sqv[cnt[1:0] - 2'd1] <= prod;
          len2 <= len2 + 22'(prod);
        end
        cnt <= cnt + 4'd1;
      end
      S_GO: ;
      S_WAIT: begin
        if (root_stat.done) begin
          unique case (comp)
            2'd0: normal_x <= res;
            2'd1: normal_y <= res[14:0];
            default: normal_z <= res;
          endcase
          comp <= comp + 2'd1;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid) else $error("result shown while accepting");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_coord |-> normal_x == 16'sd0 && normal_y == 15'd0 && normal_z == 16'sd0)
    else $error("flagged result not zero");

  a_good_vertical: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_coord |-> normal_y != 15'd0) else $error("vertical component zero");

  a_root_done_wait: assert property (@(posedge clk) disable iff (rst)
    root_stat.done |-> state == S_WAIT) else $error("root result outside wait");

  a_start_go: assert property (@(posedge clk) disable iff (rst)
    state == S_GO |=> state == S_WAIT) else $error("root start not followed by wait");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the heightmap vertex normal block.
module testbench;

  typedef struct {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
    logic               bad;
  } normal_t;

  class normal_board;
    normal_t pending[$];
    int errors;
    int checked;
    function void note(normal_t n);
      pending.push_back(n);
    endfunction
    function void check(normal_t got);
      normal_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d bad=%0b", $time,
                 got.nx, got.ny, got.nz, got.bad);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.nx !== got.nx || e.ny !== got.ny || e.nz !== got.nz || e.bad !== got.bad) begin
        $display("%0t: expected x=%0d y=%0d z=%0d bad=%0b, got x=%0d y=%0d z=%0d bad=%0b",
                 $time, e.nx, e.ny, e.nz, e.bad, got.nx, got.ny, got.nz, got.bad);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, op = 0;
  logic [5:0] col = 0, row = 0;
  logic [7:0] height = 0;
  logic out_valid, out_stall = 0;
  logic signed [15:0] normal_x, normal_z;
  logic [14:0] normal_y;
  logic bad_coord;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [7:0] cfg_data = 0;

  heightmap_vertex_normals uut (.*);

  always #10 clk = ~clk;

  normal_board board = new();
  int send_idle, recv_idle;
  int n_writes, n_queries, n_bad;
  logic [7:0] heights [hvn_pkg::DEPTH];
  bit written [hvn_pkg::DEPTH];
  int gw, gh, gdiv, eff_w, eff_h, eff_d;

  function automatic int clampv(int v, int mx);
    return v < 2 ? 2 : (v > mx ? mx : v);
  endfunction

  function automatic logic [15:0] unit_comp(longint s, longint len2, bit sat);
    longint mag, target, lo, hi, mid;
    mag = s < 0 ? -s : s;
    target = (mag * mag) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * len2 <= target) lo = mid; else hi = mid - 1;
    end
    if (s < 0) return 16'(-lo);
    if (sat && lo > 32767) lo = 32767;
    return 16'(lo);
  endfunction

  function automatic normal_t predict_normal(int c, int r);
    normal_t n;
    longint sx, sy, sz, len2;
    int fi, fj, h00;
    sx = 0; sy = 0; sz = 0;
    n.bad = 0;
    if (c >= eff_w || r >= eff_h) begin
      n.nx = 0; n.ny = 0; n.nz = 0; n.bad = 1;
      return n;
    end
    for (int k = 0; k < 4; k++) begin
      fi = c - 1 + (k & 1);
      fj = r - 1 + (k >> 1);
      if (fi < 0 || fj < 0 || fi >= eff_w - 1 || fj >= eff_h - 1) continue;
      h00 = heights[fj * eff_w + fi];
      sx += h00 - heights[fj * eff_w + fi + 1];
      sz += h00 - heights[(fj + 1) * eff_w + fi];
      sy += eff_d;
    end
    len2 = sx * sx + sy * sy + sz * sz;
    n.nx = unit_comp(sx, len2, 1);
    n.ny = 15'(unit_comp(sy, len2, 1));
    n.nz = unit_comp(sz, len2, 1);
    return n;
  endfunction

  function automatic bit query_safe(int c, int r);
    int fi, fj;
    if (c >= eff_w || r >= eff_h) return 1;
    for (int k = 0; k < 4; k++) begin
      fi = c - 1 + (k & 1);
      fj = r - 1 + (k >> 1);
      if (fi < 0 || fj < 0 || fi >= eff_w - 1 || fj >= eff_h - 1) continue;
      if (!written[fj * eff_w + fi] || !written[fj * eff_w + fi + 1]
          || !written[(fj + 1) * eff_w + fi]) return 0;
    end
    return 1;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == hvn_pkg::REG_GRID_WIDTH) gw = val & 8'h7f;
    else if (idx == hvn_pkg::REG_GRID_HEIGHT) gh = val & 8'h7f;
    else if (idx == hvn_pkg::REG_DIVISOR) gdiv = val;
    eff_w = clampv(gw, hvn_pkg::MAX_COLS);
    eff_h = clampv(gh, hvn_pkg::MAX_ROWS);
    eff_d = gdiv == 0 ? 1 : gdiv;
    if (idx != hvn_pkg::REG_DIVISOR) foreach (written[i]) written[i] = 0;
    @(posedge clk);
  endtask

  task automatic send_item(logic o, int c, int r, int h);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1;
    op <= o;
    col <= 6'(c);
    row <= 6'(r);
    height <= 8'(h);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 0;
    if (o == hvn_pkg::OP_WRITE) begin
      n_writes++;
      if (c < eff_w && r < eff_h) begin
        heights[r * eff_w + c] = 8'(h);
        written[r * eff_w + c] = 1;
      end
    end else begin
      n_queries++;
      if (c >= eff_w || r >= eff_h) n_bad++;
      board.note(predict_normal(c, r));
    end
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic fill_grid(bit ramp);
    for (int r = 0; r < eff_h; r++)
      for (int c = 0; c < eff_w; c++)
        send_item(hvn_pkg::OP_WRITE, c, r,
                  ramp ? ((c * 37 + r * 91) & 255) : $urandom_range(255));
  endtask

  task automatic random_items(int count);
    int c, r;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(63);
      r = $urandom_range(63);
      if ($urandom_range(9) < 2) begin
        c = $urandom_range(eff_w - 1);
        r = $urandom_range(eff_h - 1);
      end
      if ($urandom_range(99) < 35) send_item(hvn_pkg::OP_WRITE, c, r, $urandom_range(255));
      else begin
        if (!query_safe(c, r)) begin
          c = $urandom_range(eff_w - 1);
          r = $urandom_range(eff_h - 1);
        end
        if (query_safe(c, r)) send_item(hvn_pkg::OP_QUERY, c, r, $urandom_range(255));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check('{nx: normal_x, ny: normal_y, nz: normal_z, bad: bad_coord});
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    gw = 64; gh = 64; gdiv = 15;
    eff_w = 64; eff_h = 64; eff_d = 15;
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_idle = 25;
    recv_idle = 70;
    write_reg(hvn_pkg::REG_GRID_WIDTH, 2);
    write_reg(hvn_pkg::REG_GRID_HEIGHT, 2);
    write_reg(hvn_pkg::REG_DIVISOR, 1);
    send_item(hvn_pkg::OP_WRITE, 0, 0, 255);
    send_item(hvn_pkg::OP_WRITE, 1, 0, 0);
    send_item(hvn_pkg::OP_WRITE, 0, 1, 0);
    send_item(hvn_pkg::OP_WRITE, 1, 1, 255);
    send_item(hvn_pkg::OP_WRITE, 63, 63, 7);
    send_item(hvn_pkg::OP_WRITE, 2, 0, 9);
    for (int i = 0; i < 4; i++) send_item(hvn_pkg::OP_QUERY, i & 1, i >> 1, 255);
    send_item(hvn_pkg::OP_QUERY, 2, 0, 0);
    send_item(hvn_pkg::OP_QUERY, 63, 63, 0);
    send_item(hvn_pkg::OP_QUERY, 0, 63, 0);
    drain();

    write_reg(hvn_pkg::REG_DIVISOR, 0);
    send_item(hvn_pkg::OP_QUERY, 0, 0, 0);
    send_item(hvn_pkg::OP_QUERY, 1, 1, 0);
    drain();
    write_reg(hvn_pkg::REG_DIVISOR, 255);
    send_item(hvn_pkg::OP_QUERY, 0, 0, 0);
    drain();

    write_reg(hvn_pkg::REG_GRID_WIDTH, 5);
    write_reg(hvn_pkg::REG_GRID_HEIGHT, 4);
    write_reg(hvn_pkg::REG_DIVISOR, 15);
    fill_grid(0);
    random_items(100);
    drain();

    send_idle = 70;
    recv_idle = 25;
    write_reg(hvn_pkg::REG_GRID_WIDTH, 8'h7f);
    write_reg(hvn_pkg::REG_GRID_HEIGHT, 8'h82);
    write_reg(hvn_pkg::REG_DIVISOR, 3);
    fill_grid(1);
    send_item(hvn_pkg::OP_QUERY, 0, 0, 0);
    send_item(hvn_pkg::OP_QUERY, 63, 63, 0);
    send_item(hvn_pkg::OP_QUERY, 31, 1, 0);
    drain();
    write_reg(hvn_pkg::REG_GRID_WIDTH, 0);
    write_reg(hvn_pkg::REG_GRID_HEIGHT, 1);
    write_reg(hvn_pkg::REG_DIVISOR, 200);
    fill_grid(0);
    random_items(60);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(hvn_pkg::REG_GRID_WIDTH, 6);
    write_reg(hvn_pkg::REG_GRID_HEIGHT, 5);
    write_reg(hvn_pkg::REG_DIVISOR, 1);
    fill_grid(0);
    random_items(120);
    drain();
    write_reg(hvn_pkg::REG_GRID_WIDTH, 9);
    write_reg(hvn_pkg::REG_GRID_HEIGHT, 3);
    write_reg(hvn_pkg::REG_DIVISOR, 40);
    fill_grid(0);
    random_items(90);
    drain();

    $display("Covered %0d writes and %0d queries (%0d out of grid), %0d results checked.",
             n_writes, n_queries, n_bad, board.checked);
    $display("Grid sizes from 2x2 up to 64 columns, divisors 0 to 255, clamped register values.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("heightmap_vertex_normals: match");
    end else begin
      $display("heightmap_vertex_normals: mismatch");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("heightmap_vertex_normals: mismatch");
    $finish;
  end
endmodule

// ===== heightmap_vertex_normals.f =====
hdl/hvn_pkg.sv
hdl/hvn_store.sv
hdl/hvn_root.sv
hdl/heightmap_vertex_normals.sv
verif/testbench.sv
